FILE: design/acs_pkg.sv
// acs_pkg: shared types and codes for the alarm clock with snooze.
// Used by acs_min_adj and alarm_clock_with_snooze; no dependencies.
package acs_pkg;

  // Event kinds carried in the input beat
  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_SNOOZE   = 3'd1;
  localparam logic [2:0] KIND_TIME_UP  = 3'd2;
  localparam logic [2:0] KIND_TIME_DN  = 3'd3;
  localparam logic [2:0] KIND_ALARM_UP = 3'd4;
  localparam logic [2:0] KIND_ALARM_DN = 3'd5;
  localparam logic [2:0] KIND_END_SET  = 3'd6;

  // Adjust ramp direction
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_SNOOZE_MIN = 2'd0;
  localparam logic [1:0] REG_RAMP_HOLD  = 2'd1;
  localparam logic [1:0] REG_MAX_STEP   = 2'd2;

  localparam logic [5:0] MINUTE_MAX = 6'd59;

  // Hour/minute/half-of-day triple
  typedef struct packed {
    logic [3:0] hour;
    logic [5:0] minute;
    logic       pm;
  } hm_t;

  function automatic logic [5:0] cap59(input logic [5:0] v);
    cap59 = (v > MINUTE_MAX) ? MINUTE_MAX : v;
  endfunction

endpackage

FILE: design/acs_min_adj.sv
// acs_min_adj: adds or subtracts a minute count with hour roll and AM/PM.
// Purely combinational. Depends on acs_pkg.
module acs_min_adj (
  input  acs_pkg::hm_t cur,
  input  logic         sub,
  input  logic [5:0]   k,
  output acs_pkg::hm_t nxt
);

  logic [6:0] sum;
  logic [4:0] h_up;
  logic [3:0] h_dn;
  logic [3:0] up_hour;
  logic       up_pm;
  logic [3:0] dn_hour;
  logic       dn_pm;

  always_comb begin
    // hour up: 12 -> 1, landing on 12 flips AM/PM
    h_up    = {1'b0, cur.hour} + 5'd1;
    if (h_up == 5'd13) h_up = 5'd1;
    up_hour = h_up[3:0];
    up_pm   = (h_up == 5'd12) ? ~cur.pm : cur.pm;

    // hour down: 1 -> 12, landing on 11 flips AM/PM
    h_dn    = (cur.hour == 4'd0) ? 4'd12 : cur.hour - 4'd1;
    if (h_dn == 4'd0) h_dn = 4'd12;
    dn_hour = h_dn;
    dn_pm   = (h_dn == 4'd11) ? ~cur.pm : cur.pm;

    nxt = cur;
    if (!sub) begin
      sum = {1'b0, cur.minute} + {1'b0, k};
      if (sum > 7'd59) begin
        sum      = sum - 7'd60;
        nxt.hour = up_hour;
        nxt.pm   = up_pm;
      end
      nxt.minute = sum[5:0];
    end else begin
      sum = {1'b0, cur.minute} + 7'd60 - {1'b0, k};
      if (k > cur.minute) begin
        nxt.minute = sum[5:0];
        nxt.hour   = dn_hour;
        nxt.pm     = dn_pm;
      end else begin
        nxt.minute = cur.minute - k;
      end
    end
  end

endmodule

FILE: design/alarm_clock_with_snooze.sv
// Twelve-hour alarm clock with snooze: top level, stream in/out, APB registers.
// An accepted input beat passes through the input register, then the result register.
// Throughput: one beat per cycle unless out_tready holds the result register;
// the clock state updates as the beat leaves the input register.
// Reset: synchronous active-low rst_n; sets clock, alarm, ramp and config registers to defaults.
// Depends on acs_pkg and acs_min_adj.
module alarm_clock_with_snooze (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] kind, [3] alarm_switch, [7:4] zero
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] hour_now, [9:4] minute_now, [15:10] second_now, [16] pm_now,
  // [20:17] alarm_hour_out, [26:21] alarm_minute_out, [27] alarm_pm_out,
  // [28] sounding, [29] snoozing, [30] colon_on, [31] zero
  output logic [31:0] out_tdata,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // ---------------- configuration registers ----------------
  logic [5:0] snooze_min_r;
  logic [3:0] ramp_hold_r;
  logic [5:0] max_step_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snooze_min_r <= 6'd9;
      ramp_hold_r  <= 4'd5;
      max_step_r   <= 6'd30;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        acs_pkg::REG_SNOOZE_MIN: snooze_min_r <= cfg_pwdata[5:0];
        acs_pkg::REG_RAMP_HOLD:  ramp_hold_r  <= cfg_pwdata[3:0];
        acs_pkg::REG_MAX_STEP:   max_step_r   <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      acs_pkg::REG_SNOOZE_MIN: cfg_prdata = {26'd0, snooze_min_r};
      acs_pkg::REG_RAMP_HOLD:  cfg_prdata = {28'd0, ramp_hold_r};
      acs_pkg::REG_MAX_STEP:   cfg_prdata = {26'd0, max_step_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- input register ----------------
  // The beat waits here; it is applied to the clock state the cycle it
  // moves into the result register (adv).
  logic       in_vld_r;
  logic [2:0] kind_r;
  logic       sw_r;
  logic       out_vld_r;
  logic       adv;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tdata[2:0];
      sw_r   <= in_tdata[3];
    end
  end

  // ---------------- clock state ----------------
  acs_pkg::hm_t time_r, time_nxt;
  acs_pkg::hm_t alarm_r, alarm_nxt;
  acs_pkg::hm_t snz_r, snz_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic       snz_valid_r, snz_valid_nxt;
  logic       snz_flag_r, snz_flag_nxt;
  logic       active_r, active_nxt;
  logic       blink_r, blink_nxt;
  logic [1:0] last_dir_r, last_dir_nxt;
  logic [3:0] hold_r, hold_nxt;
  logic [5:0] step_r, step_nxt;

  // ---------------- adjust ramp ----------------
  // Repeats in one direction count up; past the hold limit the step grows
  // by one up to max_step (capped at 59). A direction change or END_SET restarts it.
  logic [1:0] dir_req;
  logic       is_adj;
  logic [4:0] hold_inc;
  logic [6:0] step_inc;
  logic [5:0] step_lim;

  always_comb begin
    case (kind_r)
      acs_pkg::KIND_TIME_UP, acs_pkg::KIND_ALARM_UP: dir_req = acs_pkg::DIR_UP;
      acs_pkg::KIND_TIME_DN, acs_pkg::KIND_ALARM_DN: dir_req = acs_pkg::DIR_DOWN;
      default:                                       dir_req = acs_pkg::DIR_NONE;
    endcase
    is_adj   = (dir_req != acs_pkg::DIR_NONE);
    hold_inc = {1'b0, hold_r} + 5'd1;
    step_inc = {1'b0, step_r} + 7'd1;
    step_lim = acs_pkg::cap59(max_step_r);

    last_dir_nxt = last_dir_r;
    hold_nxt     = hold_r;
    step_nxt     = step_r;
    if (is_adj) begin
      if (last_dir_r == dir_req) begin
        if (hold_inc > {1'b0, ramp_hold_r}) begin
          step_nxt = (step_inc > {1'b0, step_lim}) ? step_lim : step_inc[5:0];
          hold_nxt = 4'd0;
        end else begin
          hold_nxt = hold_inc[3:0];
        end
      end else begin
        hold_nxt = 4'd0;
        step_nxt = 6'd1;
      end
      last_dir_nxt = dir_req;
    end else if (kind_r == acs_pkg::KIND_END_SET) begin
      last_dir_nxt = acs_pkg::DIR_NONE;
      hold_nxt     = 4'd0;
      step_nxt     = 6'd1;
    end
  end

  // ---------------- minute adders ----------------
  acs_pkg::hm_t tm_adj, al_adj, sz_adj;
  logic [5:0]   tm_k;

  assign tm_k = (kind_r == acs_pkg::KIND_TICK) ? 6'd1 : step_nxt;

  acs_min_adj u_time_adj (
    .cur (time_r),
    .sub (kind_r == acs_pkg::KIND_TIME_DN),
    .k   (tm_k),
    .nxt (tm_adj)
  );

  acs_min_adj u_alarm_adj (
    .cur (alarm_r),
    .sub (kind_r == acs_pkg::KIND_ALARM_DN),
    .k   (step_nxt),
    .nxt (al_adj)
  );

  // snooze target: current time plus snooze minutes, second 0
  acs_min_adj u_snooze_adj (
    .cur (time_r),
    .sub (1'b0),
    .k   (acs_pkg::cap59(snooze_min_r)),
    .nxt (sz_adj)
  );

  // ---------------- event apply and alarm compare ----------------
  logic [6:0] sec_inc;
  logic       at_zero;
  logic       hit_alarm;
  logic       hit_snooze;

  always_comb begin
    sec_inc       = {1'b0, sec_r} + 7'd1;
    time_nxt      = time_r;
    sec_nxt       = sec_r;
    alarm_nxt     = alarm_r;
    snz_nxt       = snz_r;
    snz_valid_nxt = snz_valid_r;
    snz_flag_nxt  = snz_flag_r;
    active_nxt    = active_r;
    blink_nxt     = blink_r;

    case (kind_r)
      acs_pkg::KIND_TICK: begin
        blink_nxt = ~blink_r;
        if (sec_inc >= 7'd60) begin
          sec_nxt  = 6'd0;
          time_nxt = tm_adj;
        end else begin
          sec_nxt = sec_inc[5:0];
        end
      end
      acs_pkg::KIND_SNOOZE: begin
        // only while sounding; a silent press is a no-op
        if (active_r) begin
          active_nxt    = 1'b0;
          snz_flag_nxt  = 1'b1;
          snz_valid_nxt = 1'b1;
          snz_nxt       = sz_adj;
        end
      end
      acs_pkg::KIND_TIME_UP, acs_pkg::KIND_TIME_DN:   time_nxt  = tm_adj;
      acs_pkg::KIND_ALARM_UP, acs_pkg::KIND_ALARM_DN: alarm_nxt = al_adj;
      default: ;
    endcase

    at_zero    = (sec_nxt == 6'd0);
    hit_alarm  = at_zero && !snz_flag_nxt && (time_nxt == alarm_nxt);
    hit_snooze = at_zero && snz_flag_nxt && snz_valid_nxt && (time_nxt == snz_nxt);

    if (!sw_r) begin
      // switch off drops the alarm and any armed snooze
      active_nxt    = 1'b0;
      snz_flag_nxt  = 1'b0;
      snz_valid_nxt = 1'b0;
    end else if (!active_nxt && (hit_alarm || hit_snooze)) begin
      active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '{hour: 4'd12, minute: 6'd0, pm: 1'b0};
      sec_r       <= 6'd0;
      alarm_r     <= '{hour: 4'd11, minute: 6'd55, pm: 1'b1};
      snz_r       <= '{hour: 4'd12, minute: 6'd0, pm: 1'b0};
      snz_valid_r <= 1'b1;
      snz_flag_r  <= 1'b0;
      active_r    <= 1'b0;
      blink_r     <= 1'b0;
      last_dir_r  <= acs_pkg::DIR_NONE;
      hold_r      <= 4'd0;
      step_r      <= 6'd1;
    end else if (adv) begin
      time_r      <= time_nxt;
      sec_r       <= sec_nxt;
      alarm_r     <= alarm_nxt;
      snz_r       <= snz_nxt;
      snz_valid_r <= snz_valid_nxt;
      snz_flag_r  <= snz_flag_nxt;
      active_r    <= active_nxt;
      blink_r     <= blink_nxt;
      last_dir_r  <= last_dir_nxt;
      hold_r      <= hold_nxt;
      step_r      <= step_nxt;
    end
  end

  // ---------------- result register ----------------
  logic [31:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {1'b0, blink_nxt, snz_flag_nxt, active_nxt,
                     alarm_nxt.pm, alarm_nxt.minute, alarm_nxt.hour,
                     time_nxt.pm, sec_nxt, time_nxt.minute, time_nxt.hour};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    (time_r.hour >= 4'd1) && (time_r.hour <= 4'd12))
    else $error("current hour out of range");

  a_minute_range: assert property (@(posedge clk) disable iff (!rst_n)
    (time_r.minute <= 6'd59) && (alarm_r.minute <= 6'd59) && (sec_r <= 6'd59))
    else $error("minute or second out of range");

  a_step_cap: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= 6'd59)
    else $error("adjust step above cap");

  a_switch_off: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !sw_r) |=> (!active_r && !snz_flag_r && !snz_valid_r))
    else $error("alarm or snooze survived switch off");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !$past(out_vld_r)) |-> $past(adv))
    else $error("result beat without an applied input beat");
`endif

endmodule
